FILE: sv/assert_macros.svh
// Assertion macros shared by the transcoder RTL.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder: payload types, mode codes,
// the queue entry type and the UTF-8 encoder function. No dependencies.
`timescale 1ns / 1ps

package u16u8_pkg;

	localparam logic [1:0] MODE_8  = 2'd0;
	localparam logic [1:0] MODE_16 = 2'd1;
	localparam logic [1:0] MODE_32 = 2'd2;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [31:0] CP_MAX      = 32'h0010_FFFF;
	localparam logic [31:0] SUR_FIRST   = 32'h0000_D800;
	localparam logic [31:0] SUR_LAST    = 32'h0000_DFFF;
	localparam logic [20:0] REPLACEMENT = 21'h00_FFFD;
	localparam logic [20:0] SUPP_BASE   = 21'h01_0000;

	// U+FFFD encoded
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	typedef struct packed {
		logic [31:0] code_unit;
		logic        end_of_string;
	} unit_t;

	typedef struct packed {
		logic [7:0] utf8_byte;
		logic       last_of_run;
	} byte_t;

	// One classified item: an optional U+FFFD for a dropped surrogate,
	// then an optional code point (already sanitized).
	typedef struct packed {
		logic        flush;
		logic        has_cp;
		logic [20:0] cp;
	} entry_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] bytes;
	} enc_t;

	function automatic enc_t utf8_encode(input logic [20:0] cp);
		enc_t e;
		e.bytes = '0;
		if (cp <= 21'h7F) begin
			e.len      = 3'd1;
			e.bytes[0] = {1'b0, cp[6:0]};
		end else if (cp <= 21'h7FF) begin
			e.len      = 3'd2;
			e.bytes[0] = {3'b110, cp[10:6]};
			e.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			e.len      = 3'd3;
			e.bytes[0] = {4'b1110, cp[15:12]};
			e.bytes[1] = {2'b10, cp[11:6]};
			e.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			e.len      = 3'd4;
			e.bytes[0] = {5'b11110, cp[20:18]};
			e.bytes[1] = {2'b10, cp[17:12]};
			e.bytes[2] = {2'b10, cp[11:6]};
			e.bytes[3] = {2'b10, cp[5:0]};
		end
		return e;
	endfunction

endpackage

FILE: sv/utf16_to_utf8_transcoder_top.sv
// UTF-16 to UTF-8 transcoder. An accepted item passes the entry queue and
// the output register before its first byte shows. One output byte per
// cycle unless byte_stall; an item yields 1 to 7 bytes (up to 4 for one
// code point, 3 more for a flushed surrogate), a held high surrogate none.
// Items are taken every cycle while the entry queue has room. Reset (arst_n
// low) empties queue and output, drops held surrogate, sets 16-bit unit mode.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder_top #(
	parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// code unit input channel
	input  logic              unit_valid,
	output logic              unit_stall,
	input  u16u8_pkg::unit_t  unit_item,
	// UTF-8 byte output channel
	output logic              byte_valid,
	input  logic              byte_stall,
	output u16u8_pkg::byte_t  byte_item,
	// unit width mode register write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data
);

	// mode register: 0 = 8-bit, 1 = 16-bit with surrogates, 2/3 = 32-bit
	logic [1:0] mode_q;

	logic              accept, push, full, nonempty, pop;
	u16u8_pkg::entry_t new_entry, head_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= u16u8_pkg::MODE_16;
		else if (cfg_valid && cfg_ready)
			mode_q <= cfg_data;
	end

	// the front stalls only when the queue has no free slot
	assign unit_stall = full;
	assign accept     = unit_valid && !unit_stall;

	// classification and surrogate pairing
	u16u8_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.mode   (mode_q),
		.accept (accept),
		.unit   (unit_item),
		.push   (push),
		.entry  (new_entry)
	);

	// decouples item intake from byte output
	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (new_entry),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.rd_entry (head_entry)
	);

	// byte serializer with registered output
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (nonempty),
		.head       (head_entry),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item)
	);

endmodule

FILE: sv/u16u8_front.sv
// Front end: accepts code units, tracks the held high surrogate and
// classifies each item into a queue entry. Depends on u16u8_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u16u8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         mode,
	input  logic               accept,
	input  u16u8_pkg::unit_t   unit,
	output logic               push,
	output u16u8_pkg::entry_t  entry
);

	logic       pending_q;
	logic [9:0] held_q;

	logic [15:0] u;
	logic        is_hi, is_lo, mode16, pend_d;
	logic [31:0] wide;

	assign u      = unit.code_unit[15:0];
	assign is_hi  = (u[15:10] == 6'b110110);
	assign is_lo  = (u[15:10] == 6'b110111);
	assign mode16 = (mode == u16u8_pkg::MODE_16);
	assign wide   = (mode == u16u8_pkg::MODE_8) ? {24'd0, unit.code_unit[7:0]}
	                                            : unit.code_unit;

	always_comb begin
		entry.flush  = pending_q && !(mode16 && is_lo);
		entry.has_cp = 1'b1;
		entry.cp     = u16u8_pkg::REPLACEMENT;
		pend_d       = 1'b0;
		if (mode16) begin
			priority if (pending_q && is_lo) begin
				entry.cp = u16u8_pkg::SUPP_BASE + {1'b0, held_q, u[9:0]};
			end else if (is_hi) begin
				// end of string drops the high half at once
				entry.has_cp = unit.end_of_string;
				pend_d       = !unit.end_of_string;
			end else if (is_lo) begin
				entry.cp = u16u8_pkg::REPLACEMENT;
			end else begin
				entry.cp = {5'd0, u};
			end
		end else begin
			if (wide > u16u8_pkg::CP_MAX ||
			    (wide >= u16u8_pkg::SUR_FIRST && wide <= u16u8_pkg::SUR_LAST))
				entry.cp = u16u8_pkg::REPLACEMENT;
			else
				entry.cp = wide[20:0];
		end
	end

	assign push = accept && (entry.flush || entry.has_cp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			held_q    <= '0;
		end else if (accept) begin
			pending_q <= pend_d;
			if (pend_d)
				held_q <= u[9:0];
		end
	end

	// a surrogate is only ever held in 16-bit mode
	`ASSERT_NEXT(a_hold_only_16, accept && !mode16, !pending_q)
	// an item that is not pushed must leave a surrogate held
	`ASSERT_NEXT(a_silent_holds, accept && !push, pending_q)

endmodule

FILE: sv/u16u8_queue.sv
// Small FIFO between the classifier and the byte serializer.
// Depends on u16u8_pkg for the entry type.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u16u8_queue #(
	parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  u16u8_pkg::entry_t  wr_entry,
	input  logic               pop,
	output logic               full,
	output logic               nonempty,
	output u16u8_pkg::entry_t  rd_entry
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u16u8_pkg::entry_t ent_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full     = (cnt_q == CW'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rd_entry = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`ASSERT_IMPLIES(a_no_overflow, push, !full)
	`ASSERT_IMPLIES(a_no_underflow, pop, nonempty)

endmodule

FILE: sv/u16u8_back.sv
// Back end: walks the head queue entry one byte per cycle, unless stalled,
// into the output register. Depends on u16u8_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u16u8_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  u16u8_pkg::entry_t  head,
	output logic               pop,
	output logic               byte_valid,
	input  logic               byte_stall,
	output u16u8_pkg::byte_t   byte_item
);

	logic [2:0]        pos_q;
	logic              out_vld_q;
	u16u8_pkg::byte_t  out_q;

	u16u8_pkg::enc_t enc;
	logic [2:0] off, total, k;
	logic [7:0] cur;
	logic       last, load;

	always_comb begin
		enc   = u16u8_pkg::utf8_encode(head.cp);
		off   = head.flush ? 3'd3 : 3'd0;
		total = off + (head.has_cp ? enc.len : 3'd0);
		k     = pos_q - off;
		last  = (pos_q == total - 3'd1);
		if (head.flush && pos_q < 3'd3) begin
			unique case (pos_q[1:0])
				2'd0:    cur = u16u8_pkg::REPL_B0;
				2'd1:    cur = u16u8_pkg::REPL_B1;
				default: cur = u16u8_pkg::REPL_B2;
			endcase
		end else begin
			cur = enc.bytes[k[1:0]];
		end
	end

	assign load = head_valid && (!out_vld_q || !byte_stall);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
			pos_q     <= last ? 3'd0 : pos_q + 3'd1;
		end else if (!byte_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.utf8_byte   <= cur;
			out_q.last_of_run <= last;
		end
	end

	assign byte_valid = out_vld_q;
	assign byte_item  = out_q;

	// never walk past the end of an entry
	`ASSERT_IMPLIES(a_pos_in_range, head_valid, pos_q < total)

endmodule
